### sv/cfa_pkg.sv
package cfa_pkg;

  // Input beat layout (tdata), lowest bit first
  localparam int unsigned IdW      = 16;
  localparam int unsigned PosW     = 32;
  localparam int unsigned ChgW     = 32;
  localparam int unsigned InDataW  = 288;
  localparam int unsigned ForceW   = 64;
  localparam int unsigned OutDataW = 3 * ForceW;

  localparam int unsigned TgtIdLsb  = 0;
  localparam int unsigned TgtPosLsb = 16;
  localparam int unsigned TgtChgLsb = 112;
  localparam int unsigned SrcIdLsb  = 144;
  localparam int unsigned SrcPosLsb = 160;
  localparam int unsigned SrcChgLsb = 256;

  // Configuration
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ScaleW    = 32;
  localparam int unsigned MinDistW  = 31;
  localparam logic [CfgIdxW-1:0] CFG_FORCE_SCALE  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DISTANCE = 1'b1;
  localparam logic [ScaleW-1:0]   SCALE_RESET   = 32'h0001_0000;
  localparam logic [MinDistW-1:0] MINDIST_RESET = 31'd1;

  // Datapath widths
  localparam int unsigned DMagW   = 33;   // |target - source|
  localparam int unsigned RootW   = 34;   // distance
  localparam int unsigned RadW    = 66;   // sum of squares
  localparam int unsigned SremW   = 37;
  localparam int unsigned SqrtSteps = RadW / 2;
  localparam int unsigned ProdW   = 130;  // shared multiplier product
  localparam int unsigned MulBW   = 34;
  localparam int unsigned SbW     = 96;   // scale * |q1 q2|
  localparam int unsigned DenW    = 102;  // distance cubed
  localparam int unsigned NumW    = 192;
  localparam int unsigned QuotW   = 64;

  // Multiplier operations
  localparam logic [2:0] MUL_SQX = 3'd0;
  localparam logic [2:0] MUL_SQY = 3'd1;
  localparam logic [2:0] MUL_SQZ = 3'd2;
  localparam logic [2:0] MUL_R2  = 3'd3;
  localparam logic [2:0] MUL_R3  = 3'd4;
  localparam logic [2:0] MUL_QQ  = 3'd5;
  localparam logic [2:0] MUL_SB  = 3'd6;
  localparam logic [2:0] MUL_AX  = 3'd7;

  typedef struct packed {
    logic       load;
    logic       mul_start;
    logic [2:0] mul_op;
    logic       sqrt_start;
    logic       div_start;
    logic       acc_add;
    logic       emit;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic sqrt_busy;
    logic div_busy;
    logic skip;
    logic last;
    logic out_free;
  } sts_t;

endpackage

### sv/cfa_mul.sv
module cfa_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cfa_pkg::ProdW-1:0]  a_i,
  input  logic [cfa_pkg::MulBW-1:0]  b_i,
  input  logic [cfa_pkg::ProdW-1:0]  p_init_i,
  output logic [cfa_pkg::ProdW-1:0]  p_o,
  output logic                       busy_o
);

  logic [cfa_pkg::ProdW-1:0] a_q, a_d, p_q, p_d;
  logic [cfa_pkg::MulBW-1:0] b_q, b_d;
  logic                      busy_q, busy_d;

  // shift-add: one multiplier bit per cycle, stop once no bits remain
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      p_d    = p_init_i;
      busy_d = (b_i != '0);
    end else if (busy_q) begin
      if (b_q[0]) begin
        p_d = p_q + a_q;
      end
      a_d    = a_q << 1;
      b_d    = b_q >> 1;
      busy_d = ((b_q >> 1) != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign p_o    = p_q;
  assign busy_o = busy_q;

endmodule

### sv/cfa_datapath.sv
module cfa_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfa_pkg::cmd_t                 cmd_i,
  output cfa_pkg::sts_t                 sts_o,
  input  logic [cfa_pkg::InDataW-1:0]   in_data_i,
  input  logic                          in_last_i,
  input  logic                          cfg_we_i,
  input  logic [cfa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cfa_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cfa_pkg::OutDataW-1:0]  out_data_o
);

  localparam int unsigned NumShift = FRAC_BITS + 32;

  // configuration
  logic [cfa_pkg::ScaleW-1:0]   scale_q;
  logic [cfa_pkg::MinDistW-1:0] mindist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= cfa_pkg::SCALE_RESET;
      mindist_q <= cfa_pkg::MINDIST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfa_pkg::CFG_FORCE_SCALE:  scale_q   <= cfg_data_i;
        cfa_pkg::CFG_MIN_DISTANCE: mindist_q <= cfg_data_i[cfa_pkg::MinDistW-1:0];
        default: ;
      endcase
    end
  end

  // pair registers
  logic [cfa_pkg::DMagW-1:0] dmag_q [3];
  logic [2:0]                dneg_q;
  logic [31:0]               qa_q, qb_q;
  logic                      qneg_q, skip_q, last_q;

  logic [cfa_pkg::DMagW-1:0] diff [3];
  logic [cfa_pkg::PosW-1:0]  tpos [3];
  logic [cfa_pkg::PosW-1:0]  spos [3];
  logic [cfa_pkg::ChgW-1:0]  tchg, schg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tpos[i] = in_data_i[cfa_pkg::TgtPosLsb + i*cfa_pkg::PosW +: cfa_pkg::PosW];
      spos[i] = in_data_i[cfa_pkg::SrcPosLsb + i*cfa_pkg::PosW +: cfa_pkg::PosW];
      diff[i] = {tpos[i][31], tpos[i]} - {spos[i][31], spos[i]};
    end
    tchg = in_data_i[cfa_pkg::TgtChgLsb +: cfa_pkg::ChgW];
    schg = in_data_i[cfa_pkg::SrcChgLsb +: cfa_pkg::ChgW];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        dneg_q[i] <= diff[i][32];
        dmag_q[i] <= diff[i][32] ? (~diff[i] + 1'b1) : diff[i];
      end
      qa_q   <= tchg[31] ? (~tchg + 1'b1) : tchg;
      qb_q   <= schg[31] ? (~schg + 1'b1) : schg;
      qneg_q <= tchg[31] ^ schg[31];
      skip_q <= in_data_i[cfa_pkg::TgtIdLsb +: cfa_pkg::IdW] ==
                in_data_i[cfa_pkg::SrcIdLsb +: cfa_pkg::IdW];
      last_q <= in_last_i;
    end
  end

  // shared multiplier and its operand selection
  logic [cfa_pkg::ProdW-1:0] mul_a, mul_p0, p;
  logic [cfa_pkg::MulBW-1:0] mul_b;
  logic                      mul_busy;
  logic [cfa_pkg::RootW-1:0] root_q, rc_q, rc;
  logic [cfa_pkg::RootW-1:0] rmin;
  logic [cfa_pkg::SbW-1:0]   sb_q, sb_src;
  logic [cfa_pkg::DenW-1:0]  den_q;

  assign rmin   = (mindist_q == '0) ? cfa_pkg::RootW'(1) : cfa_pkg::RootW'(mindist_q);
  assign rc     = (root_q < rmin) ? rmin : root_q;
  assign sb_src = (cmd_i.axis == 2'd0) ? p[cfa_pkg::SbW-1:0] : sb_q;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_p0 = '0;
    case (cmd_i.mul_op)
      cfa_pkg::MUL_SQX: begin
        mul_a = cfa_pkg::ProdW'(dmag_q[0]);
        mul_b = cfa_pkg::MulBW'(dmag_q[0]);
      end
      cfa_pkg::MUL_SQY: begin
        mul_a  = cfa_pkg::ProdW'(dmag_q[1]);
        mul_b  = cfa_pkg::MulBW'(dmag_q[1]);
        mul_p0 = p;
      end
      cfa_pkg::MUL_SQZ: begin
        mul_a  = cfa_pkg::ProdW'(dmag_q[2]);
        mul_b  = cfa_pkg::MulBW'(dmag_q[2]);
        mul_p0 = p;
      end
      cfa_pkg::MUL_R2: begin
        mul_a = cfa_pkg::ProdW'(rc);
        mul_b = rc;
      end
      cfa_pkg::MUL_R3: begin
        mul_a = p;
        mul_b = rc_q;
      end
      cfa_pkg::MUL_QQ: begin
        mul_a = cfa_pkg::ProdW'(qa_q);
        mul_b = cfa_pkg::MulBW'(qb_q);
      end
      cfa_pkg::MUL_SB: begin
        mul_a = p;
        mul_b = cfa_pkg::MulBW'(scale_q);
      end
      cfa_pkg::MUL_AX: begin
        mul_a = cfa_pkg::ProdW'(sb_src);
        mul_b = cfa_pkg::MulBW'(dmag_q[cmd_i.axis]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      if (cmd_i.mul_op == cfa_pkg::MUL_R2) begin
        rc_q <= rc;
      end
      if (cmd_i.mul_op == cfa_pkg::MUL_QQ) begin
        den_q <= p[cfa_pkg::DenW-1:0];
      end
      if (cmd_i.mul_op == cfa_pkg::MUL_AX) begin
        sb_q <= sb_src;
      end
    end
  end

  cfa_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .p_init_i (mul_p0),
    .p_o      (p),
    .busy_o   (mul_busy)
  );

  // integer square root, two radicand bits per cycle
  logic [cfa_pkg::RadW-1:0]  rad_q;
  logic [cfa_pkg::SremW-1:0] srem_q, srem_s, strial;
  logic [5:0]                scnt_q;
  logic                      sbusy_q;

  assign srem_s = {srem_q[cfa_pkg::SremW-3:0], rad_q[cfa_pkg::RadW-1 -: 2]};
  assign strial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
    end else if (cmd_i.sqrt_start) begin
      sbusy_q <= 1'b1;
    end else if (sbusy_q && scnt_q == 6'(cfa_pkg::SqrtSteps - 1)) begin
      sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= p[cfa_pkg::RadW-1:0];
      srem_q <= '0;
      root_q <= '0;
      scnt_q <= '0;
    end else if (sbusy_q) begin
      rad_q  <= rad_q << 2;
      scnt_q <= scnt_q + 1'b1;
      if (srem_s >= strial) begin
        srem_q <= srem_s - strial;
        root_q <= {root_q[cfa_pkg::RootW-2:0], 1'b1};
      end else begin
        srem_q <= srem_s;
        root_q <= {root_q[cfa_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  // restoring divider for the low 64 quotient bits; overflow flagged up front
  logic [cfa_pkg::NumW-1:0]    nfull;
  logic [cfa_pkg::NumW-65:0]   nhigh;
  logic [cfa_pkg::DenW-1:0]    drem_q;
  logic [cfa_pkg::DenW:0]      drem_s;
  logic [63:0]                 nlo_q;
  logic [cfa_pkg::QuotW-1:0]   quot_q;
  logic [6:0]                  dcnt_q;
  logic                        dbusy_q, sat_q;

  assign nfull  = cfa_pkg::NumW'(p) << NumShift;
  assign nhigh  = nfull[cfa_pkg::NumW-1:64];
  assign drem_s = {drem_q, nlo_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
    end else if (dbusy_q && dcnt_q == 7'(cfa_pkg::QuotW - 1)) begin
      dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      sat_q  <= nhigh >= (cfa_pkg::NumW-64)'(den_q);
      drem_q <= nhigh[cfa_pkg::DenW-1:0];
      nlo_q  <= nfull[63:0];
      quot_q <= '0;
      dcnt_q <= '0;
    end else if (dbusy_q) begin
      nlo_q  <= nlo_q << 1;
      dcnt_q <= dcnt_q + 1'b1;
      if (drem_s >= {1'b0, den_q}) begin
        drem_q <= cfa_pkg::DenW'(drem_s - {1'b0, den_q});
        quot_q <= {quot_q[cfa_pkg::QuotW-2:0], 1'b1};
      end else begin
        drem_q <= drem_s[cfa_pkg::DenW-1:0];
        quot_q <= {quot_q[cfa_pkg::QuotW-2:0], 1'b0};
      end
    end
  end

  // signed term and saturating accumulate
  logic [cfa_pkg::ForceW-1:0] sum_q [3];
  logic [cfa_pkg::ForceW-1:0] term, sum_sel, sum_new;
  logic [cfa_pkg::ForceW:0]   sum_w;
  logic                       tneg, tsat;

  localparam logic [cfa_pkg::ForceW-1:0] SMax = {1'b0, {(cfa_pkg::ForceW-1){1'b1}}};
  localparam logic [cfa_pkg::ForceW-1:0] SMin = {1'b1, {(cfa_pkg::ForceW-1){1'b0}}};

  always_comb begin
    tneg    = qneg_q ^ dneg_q[cmd_i.axis];
    tsat    = sat_q | quot_q[cfa_pkg::QuotW-1];
    if (tsat) begin
      term = tneg ? SMin : SMax;
    end else begin
      term = tneg ? (~quot_q + 1'b1) : quot_q;
    end
    sum_sel = sum_q[cmd_i.axis];
    sum_w   = {sum_sel[63], sum_sel} + {term[63], term};
    if (sum_w[64] != sum_w[63]) begin
      sum_new = sum_w[64] ? SMin : SMax;
    end else begin
      sum_new = sum_w[63:0];
    end
  end

  logic                         out_valid_q;
  logic [cfa_pkg::OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
        end
      end else if (cmd_i.acc_add) begin
        sum_q[cmd_i.axis] <= sum_new;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {sum_q[2], sum_q[1], sum_q[0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.mul_busy  = mul_busy;
  assign sts_o.sqrt_busy = sbusy_q;
  assign sts_o.div_busy  = dbusy_q;
  assign sts_o.skip      = skip_q;
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### sv/cfa_ctrl.sv
module cfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cfa_pkg::sts_t sts_i,
  output cfa_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SQX  = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_SQZ  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_R2   = 4'd6;
  localparam logic [3:0] S_R3   = 4'd7;
  localparam logic [3:0] S_QQ   = 4'd8;
  localparam logic [3:0] S_SB   = 4'd9;
  localparam logic [3:0] S_NEXT = 4'd10;
  localparam logic [3:0] S_AXM  = 4'd11;
  localparam logic [3:0] S_AXD  = 4'd12;
  localparam logic [3:0] S_ACC  = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.skip) begin
          state_d = sts_i.last ? S_EMIT : S_IDLE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = cfa_pkg::MUL_SQX;
          state_d         = S_SQX;
        end
      end
      S_SQX: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = cfa_pkg::MUL_SQY;
          state_d         = S_SQY;
        end
      end
      S_SQY: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = cfa_pkg::MUL_SQZ;
          state_d         = S_SQZ;
        end
      end
      S_SQZ: begin
        if (!sts_i.mul_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = cfa_pkg::MUL_R2;
          state_d         = S_R2;
        end
      end
      S_R2: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = cfa_pkg::MUL_R3;
          state_d         = S_R3;
        end
      end
      S_R3: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = cfa_pkg::MUL_QQ;
          state_d         = S_QQ;
        end
      end
      S_QQ: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = cfa_pkg::MUL_SB;
          state_d         = S_SB;
        end
      end
      S_SB: begin
        if (!sts_i.mul_busy) begin
          axis_d  = 2'd0;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = cfa_pkg::MUL_AX;
        state_d         = S_AXM;
      end
      S_AXM: begin
        if (!sts_i.mul_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_AXD;
        end
      end
      S_AXD: begin
        if (!sts_i.div_busy) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_add = 1'b1;
        if (axis_q == 2'd2) begin
          axis_d  = 2'd0;
          state_d = sts_i.last ? S_EMIT : S_IDLE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_NEXT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule

### sv/coulomb_force_accumulator_top.sv
// Coulomb force accumulator.
// Slave stream: one beat per (target, source) particle pair; tlast marks the
// last source for the current target. Pairs with equal ids add nothing.
// Master stream: one beat of summed force (x, y, z, signed Q32.32, saturated)
// for every slave beat that carried tlast; the sums clear after it.
// Config channel: index 0 writes force_scale, index 1 writes min_distance.
// Write it only while no pair is in flight.
// Pairs are taken one at a time. The time a pair takes is set by the shared
// bit-serial multiplier (one multiplier bit per cycle, ten operations per
// pair), the 33-step square root and three 64-step divisions. A skipped
// pair goes straight back to idle, or to the emit state when it carries
// tlast. The force beat is registered, loaded once the last pair finishes
// and the output register is free. The output register holds it while
// the receiver stalls; the block keeps taking new pairs meanwhile and only
// waits when a second result is ready before the first has left.
// Reset: sums clear, force_scale returns to 1.0 and min_distance to one LSB.
module coulomb_force_accumulator_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // target_id, target_pos_x, target_pos_y, target_pos_z, target_charge,
  // source_id, source_pos_x, source_pos_y, source_pos_z, source_charge
  input  logic [cfa_pkg::InDataW-1:0]   s_tdata,
  input  logic                          s_tlast,   // last_pair
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // force_x, force_y, force_z
  output logic [cfa_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cfa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cfa_pkg::CfgDataW-1:0]  cfg_data_i
);

  cfa_pkg::cmd_t cmd;
  cfa_pkg::sts_t sts;

  // config writes land at once
  assign cfg_ready_o = 1'b1;

  cfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfa_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_tdata),
    .in_last_i   (s_tlast),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata)
  );

endmodule

### sim/coulomb_force_accumulator_top_tb.sv
`timescale 1ns / 1ps

module coulomb_force_accumulator_top_tb;

  typedef struct {
    logic [15:0] tgt_id;
    logic [31:0] tgt_x, tgt_y, tgt_z, tgt_q;
    logic [15:0] src_id;
    logic [31:0] src_x, src_y, src_z, src_q;
    logic        last;
  } pair_t;

  typedef struct {
    logic [63:0] fx, fy, fz;
  } force_t;

  // Predicts the summed force per target and checks each force beat against it
  class force_board;
    logic [31:0] scale;
    logic [30:0] min_dist;
    logic signed [63:0] sum_x, sum_y, sum_z;
    force_t pending[$];
    int errors;
    int forces_seen;

    function new();
      scale = cfa_pkg::SCALE_RESET;
      min_dist = cfa_pkg::MINDIST_RESET;
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      errors = 0;
      forces_seen = 0;
    endfunction

    function void write_reg(logic [cfa_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
      if (idx == cfa_pkg::CFG_FORCE_SCALE) scale = data;
      else min_dist = data[30:0];
    endfunction

    function logic signed [63:0] sat_sum(logic signed [63:0] s, logic signed [63:0] c);
      logic signed [64:0] w;
      w = 65'(s) + 65'(c);
      if (w > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (w < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return w[63:0];
    endfunction

    // Axis term: base * |d| / r^3, truncated, then saturated to 64 bits
    function logic signed [63:0] axis_force(logic [255:0] base, bit qneg,
                                            logic signed [33:0] d, logic [255:0] den);
      logic [255:0] num, quo;
      logic [33:0] mag;
      bit neg;
      if (d == 0) return 0;
      mag = d < 0 ? -d : d;
      neg = qneg != (d < 0);
      num = base * 256'(mag);
      quo = num / den;
      if (quo >= 256'h8000_0000_0000_0000)
        return neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

    function void note_pair(pair_t p);
      logic signed [33:0] dx, dy, dz;
      logic signed [31:0] q1, q2;
      logic [79:0] rad, cand;
      logic [34:0] r, c, rmin;
      logic [255:0] den, base;
      logic [63:0] qmag;
      bit qneg;
      force_t f;
      if (p.tgt_id != p.src_id) begin
        dx = $signed({p.tgt_x[31], p.tgt_x}) - $signed({p.src_x[31], p.src_x});
        dy = $signed({p.tgt_y[31], p.tgt_y}) - $signed({p.src_y[31], p.src_y});
        dz = $signed({p.tgt_z[31], p.tgt_z}) - $signed({p.src_z[31], p.src_z});
        rad = 80'(80'(dx) * 80'(dx)) + 80'(80'(dy) * 80'(dy)) + 80'(80'(dz) * 80'(dz));
        r = 0;
        for (int b = 34; b >= 0; b--) begin
          c = r | (35'd1 << b);
          cand = 80'(c) * 80'(c);
          if (cand <= rad) r = c;
        end
        rmin = (min_dist == 0) ? 35'd1 : 35'(min_dist);
        if (r < rmin) r = rmin;
        den = 256'(r) * 256'(r) * 256'(r);
        q1 = p.tgt_q;
        q2 = p.src_q;
        qmag = 64'(q1 < 0 ? -33'(q1) : 33'(q1)) * 64'(q2 < 0 ? -33'(q2) : 33'(q2));
        qneg = (q1 < 0) != (q2 < 0);
        base = (256'(scale) * 256'(qmag)) << 48;
        sum_x = sat_sum(sum_x, axis_force(base, qneg, dx, den));
        sum_y = sat_sum(sum_y, axis_force(base, qneg, dy, den));
        sum_z = sat_sum(sum_z, axis_force(base, qneg, dz, den));
      end
      if (p.last) begin
        f.fx = sum_x;
        f.fy = sum_y;
        f.fz = sum_z;
        pending.push_back(f);
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
      end
    endfunction

    function void check_force(logic [cfa_pkg::OutDataW-1:0] data);
      force_t f;
      forces_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: force beat with none expected, actual %h", $time, data);
        return;
      end
      f = pending.pop_front();
      if (data[63:0] !== f.fx) begin
        errors++;
        $display("%0t: force_x expected %h actual %h", $time, f.fx, data[63:0]);
      end
      if (data[127:64] !== f.fy) begin
        errors++;
        $display("%0t: force_y expected %h actual %h", $time, f.fy, data[127:64]);
      end
      if (data[191:128] !== f.fz) begin
        errors++;
        $display("%0t: force_z expected %h actual %h", $time, f.fz, data[191:128]);
      end
    endfunction
  endclass

  localparam int unsigned DrainCycles = 800;
  localparam longint unsigned CycleLimit = 8_000_000;

  logic clk_i;
  logic rst_ni;
  logic s_tvalid, s_tready, s_tlast;
  logic [cfa_pkg::InDataW-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [cfa_pkg::OutDataW-1:0] m_tdata;
  logic cfg_valid_i, cfg_ready_o;
  logic [cfa_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [cfa_pkg::CfgDataW-1:0] cfg_data_i;

  force_board board;
  longint unsigned cycles = 0;
  int pairs_sent;
  int cfg_writes;

  coulomb_force_accumulator_top dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Run watchdog: count every cycle and bail out well past the slowest run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL coulomb_force_accumulator_top");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic cfg_write(logic [cfa_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Drive one pair beat; valid stays high when the next beat follows at once
  task automatic send_pair(pair_t p);
    int gap;
    s_tvalid <= 1'b1;
    s_tlast  <= p.last;
    s_tdata  <= {p.src_q, p.src_z, p.src_y, p.src_x, p.src_id,
                 p.tgt_q, p.tgt_z, p.tgt_y, p.tgt_x, p.tgt_id};
    do @(posedge clk_i); while (!s_tready);
    board.note_pair(p);
    pairs_sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every force is back, then let stray pairs finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic pair_t random_pair(bit last);
    pair_t p;
    logic [31:0] off;
    p.tgt_id = 16'($urandom);
    p.src_id = ($urandom_range(9) == 0) ? p.tgt_id : 16'($urandom);
    p.tgt_x = $urandom;
    p.tgt_y = $urandom;
    p.tgt_z = $urandom;
    case ($urandom_range(3))
      0: begin
        p.src_x = $urandom;
        p.src_y = $urandom;
        p.src_z = $urandom;
      end
      1: begin
        p.src_x = p.tgt_x;
        p.src_y = p.tgt_y;
        p.src_z = p.tgt_z;
        if ($urandom_range(1)) p.src_z = p.tgt_z + 32'($urandom_range(255));
      end
      default: begin
        off = $urandom_range(1 << 20);
        p.src_x = p.tgt_x - off + 32'($urandom_range(1 << 19));
        p.src_y = p.tgt_y + 32'($urandom_range(1 << 18)) - 32'(1 << 17);
        p.src_z = p.tgt_z - 32'($urandom_range(1 << 16));
      end
    endcase
    p.tgt_q = pick_word();
    p.src_q = pick_word();
    p.last = last;
    return p;
  endfunction

  // Random sets of pairs per target; most sets short
  task automatic random_sets(int n_pairs);
    int left;
    int set_len;
    left = n_pairs;
    while (left > 0) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
      if (set_len > left) set_len = left;
      for (int k = 0; k < set_len; k++) send_pair(random_pair(k == set_len - 1));
      left -= set_len;
    end
  endtask

  task automatic directed();
    pair_t p;
    // Farthest pair on x with extreme charges of like sign
    p = random_pair(1'b1);
    p.src_id = ~p.tgt_id;
    p.tgt_x = 32'h7FFF_FFFF; p.src_x = 32'h8000_0000;
    p.tgt_y = 0; p.src_y = 0; p.tgt_z = 0; p.src_z = 0;
    p.tgt_q = 32'h8000_0000; p.src_q = 32'h8000_0000;
    send_pair(p);
    // Same on all axes, opposite charges
    p.tgt_y = 32'h8000_0000; p.src_y = 32'h7FFF_FFFF;
    p.tgt_z = 32'h7FFF_FFFF; p.src_z = 32'h8000_0000;
    p.src_q = 32'h7FFF_FFFF;
    send_pair(p);
    // Coincident particles, then a close pair, in one set
    p = random_pair(1'b0);
    p.src_id = p.tgt_id ^ 16'hFFFF;
    p.src_x = p.tgt_x; p.src_y = p.tgt_y; p.src_z = p.tgt_z;
    send_pair(p);
    p.src_z = p.tgt_z + 1;
    p.last = 1'b1;
    send_pair(p);
    // Equal ids alone still emit a zero force
    p = random_pair(1'b1);
    p.src_id = p.tgt_id;
    send_pair(p);
    // Zero charge, then full-scale ids and a set that saturates the sums
    p = random_pair(1'b1);
    p.tgt_q = 0;
    send_pair(p);
    p = random_pair(1'b0);
    p.tgt_id = 16'hFFFF; p.src_id = 16'h0000;
    p.src_x = p.tgt_x + 1; p.src_y = p.tgt_y; p.src_z = p.tgt_z;
    p.tgt_q = 32'h7FFF_FFFF; p.src_q = 32'h7FFF_FFFF;
    repeat (3) send_pair(p);
    p.tgt_q = 32'h8000_0000;
    p.last = 1'b1;
    send_pair(p);
    for (int k = 0; k < 8; k++) send_pair(random_pair(k[0]));
    send_pair(random_pair(1'b1));
  endtask

  // Receiver: check every force beat, idle in bursts, and once stall long
  // enough that a second result backs up and the input stalls too.
  initial begin
    int hold;
    int busy_pct;
    bit stalled;
    hold = 0;
    busy_pct = 0;
    stalled = 0;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) board.check_force(m_tdata);
      if (cycles % 512 == 0) busy_pct = $urandom_range(2) * 25;
      if (!stalled && board.forces_seen >= 30) begin
        stalled = 1;
        hold = 8000;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if ($urandom_range(99) < busy_pct) begin
        hold = gap_len();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    board = new();
    pairs_sent = 0;
    cfg_writes = 0;
    s_tvalid = 1'b0;
    s_tlast = 1'b0;
    s_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = cfa_pkg::CFG_FORCE_SCALE;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings first
    directed();
    random_sets(300);
    drain();

    // Largest scale, clamp at zero (read as one)
    cfg_write(cfa_pkg::CFG_FORCE_SCALE, 32'hFFFF_FFFF);
    cfg_write(cfa_pkg::CFG_MIN_DISTANCE, 32'h0);
    random_sets(300);
    drain();

    // Zero scale, largest clamp
    cfg_write(cfa_pkg::CFG_FORCE_SCALE, 32'h0);
    cfg_write(cfa_pkg::CFG_MIN_DISTANCE, 32'h7FFF_FFFF);
    random_sets(150);
    drain();

    // Random scale, moderate clamp, a few rounds
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(cfa_pkg::CFG_FORCE_SCALE, $urandom);
      cfg_write(cfa_pkg::CFG_MIN_DISTANCE, {1'b0, 31'($urandom_range(1 << 22))});
      random_sets(200);
      drain();
    end

    $display("Covered %0d pairs, %0d force beats, %0d register writes over 7 settings.",
             pairs_sent, board.forces_seen, cfg_writes);
    if (board.errors == 0) begin
      $display("PASS coulomb_force_accumulator_top");
    end else begin
      $display("FAIL coulomb_force_accumulator_top");
    end
    $finish;
  end

endmodule
